// ----- rtl/core/slle_pkg.sv -----
// shared types and codes for the static linked list engine
// no dependencies; imported by the controller, the datapath and the top level
`timescale 1ns / 1ps

package slle_pkg;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  position;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [7:0]  item_count;
    logic        list_empty;
  } rsp_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_INS_POP,
    S_WALK,
    S_INS_WR_NODE,
    S_INS_WR_PREV,
    S_REM_HEAD,
    S_REM_NODE,
    S_REM_UNLINK,
    S_REM_FREE,
    S_RD_TAKE,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {LRA_WALK, LRA_FREE, LRA_HEAD, LRA_LRD} link_ra_t;
  typedef enum logic [1:0] {WRA_WALK, WRA_HEAD, WRA_LRD} word_ra_t;
  typedef enum logic [2:0] {
    LW_NONE, LW_INIT, LW_NODE_HEAD, LW_NODE_LRD, LW_CUR_NODE, LW_CUR_LRD, LW_NODE_FREE
  } link_wr_t;
  typedef enum logic [1:0] {NODE_KEEP, NODE_FREE, NODE_HEAD, NODE_LRD} node_sel_t;
  typedef enum logic [1:0] {FREE_KEEP, FREE_LRD, FREE_NODE} free_upd_t;
  typedef enum logic [1:0] {HEAD_KEEP, HEAD_NODE, HEAD_LRD} head_upd_t;

  // controller to datapath
  typedef struct packed {
    logic      req_load;
    logic      status_load;
    link_ra_t  link_ra;
    word_ra_t  word_ra;
    link_wr_t  link_wr;
    logic      word_we;
    node_sel_t node_sel;
    free_upd_t free_upd;
    head_upd_t head_upd;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      walk_start;
    logic      walk_skip;
    logic      walk_step;
    logic      walk_end;
    logic      rd_load;
    logic      out_load;
    logic      init_wr;
  } slle_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       pos_one;
    logic       err;
    logic       steps_zero;
    logic       init_last;
    logic       out_busy;
  } slle_sts_t;

endpackage

// ----- rtl/core/static_linked_list_engine_core.sv -----
// positional list engine with a free list threaded through a DEPTH-entry node store
// a request is checked and then, where needed, walks from the head to its position, following
// one link per cycle through the single read port of the link memory; then it updates the links
// and loads the result into the output register once that register is free. after reset a
// clearing pass chains every entry into the free list; no request is taken until it ends. one
// request is in flight at a time, and the next one is taken while the previous result still
// waits in the output register.
// depends on slle_pkg, slle_ctrl and slle_datapath
`timescale 1ns / 1ps

module static_linked_list_engine_core import slle_pkg::*; #(
  parameter int DEPTH = 128
) (
  input  logic clk,
  input  logic rst_n,
  // request channel
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  // result channel
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  // command and status between sequencer and datapath
  slle_cmd_t cmd;
  slle_sts_t sts;

  // sequencer: one state per list update step, walk loops in a single state
  slle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: link and word memories, head and free pointers, count, output register
  slle_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/slle_datapath.sv -----
// node store, list pointers, walk counter and result register
// depends on slle_pkg
`timescale 1ns / 1ps

module slle_datapath import slle_pkg::*; #(
  parameter int DEPTH = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  input  req_t      in_data,
  input  slle_cmd_t cmd,
  output slle_sts_t sts,
  input  logic      out_ready,
  output logic      out_valid,
  output rsp_t      out_data
);

  localparam int IW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int MW = (IW > 8 ? IW : 8) + 1;
  localparam logic [IW-1:0] NULL_IDX = IW'(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  logic [IW-1:0] link_mem [DEPTH];
  logic [31:0]   word_mem [DEPTH];

  req_t          req_r;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] free_r, free_nxt;
  logic [IW-1:0] node_r, node_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] count_r, count_nxt;
  logic [7:0]    steps_r, steps_nxt;
  logic          fwd_r, fwd_nxt;
  logic [IW-1:0] init_idx_r;
  logic [IW-1:0] link_rd_r;
  logic [31:0]   word_rd_r;
  logic [31:0]   rd_r;
  logic [1:0]    status_r;
  logic          out_valid_r;
  rsp_t          out_data_r;

  logic [IW-1:0] cur_x;
  logic [IW-1:0] link_ra, word_ra;
  logic          link_we;
  logic [IW-1:0] link_wa, link_wd;
  logic [1:0]    dec_status;
  logic [MW-1:0] pos_w, cnt_w;
  logic          full;

  // walk pointer: the last link read while walking, else the start point
  assign cur_x = fwd_r ? link_rd_r : cur_r;

  // request check
  always_comb begin
    pos_w = MW'(req_r.position);
    cnt_w = MW'(count_r);
    full  = (free_r >= NULL_IDX) || (count_r >= NULL_IDX);
    dec_status = STAT_OK;
    case (req_r.op)
      OP_INSERT: begin
        if (full) dec_status = STAT_FULL;
        else if (pos_w == '0 || pos_w > cnt_w + MW'(1)) dec_status = STAT_RANGE;
      end
      OP_REMOVE, OP_READ: begin
        if (pos_w == '0 || pos_w > cnt_w) dec_status = STAT_RANGE;
      end
      default: dec_status = STAT_OK;
    endcase
  end

  assign sts.op         = req_r.op;
  assign sts.pos_one    = (req_r.position == 8'd1);
  assign sts.err        = (dec_status != STAT_OK);
  assign sts.steps_zero = (steps_r == 8'd0);
  assign sts.init_last  = (init_idx_r == LAST_IDX);
  assign sts.out_busy   = out_valid_r;

  // memory address and write selection
  always_comb begin
    case (cmd.link_ra)
      LRA_FREE: link_ra = free_r;
      LRA_HEAD: link_ra = head_r;
      LRA_LRD:  link_ra = link_rd_r;
      default:  link_ra = cur_x;
    endcase
    case (cmd.word_ra)
      WRA_HEAD: word_ra = head_r;
      WRA_LRD:  word_ra = link_rd_r;
      default:  word_ra = cur_x;
    endcase
    link_we = 1'b1;
    link_wa = node_r;
    link_wd = head_r;
    case (cmd.link_wr)
      LW_INIT: begin
        link_wa = init_idx_r;
        link_wd = init_idx_r + IW'(1);
      end
      LW_NODE_HEAD: link_wd = head_r;
      LW_NODE_LRD:  link_wd = link_rd_r;
      LW_CUR_NODE: begin
        link_wa = cur_r;
        link_wd = node_r;
      end
      LW_CUR_LRD: begin
        link_wa = cur_r;
        link_wd = link_rd_r;
      end
      LW_NODE_FREE: link_wd = free_r;
      default: link_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa[AW-1:0]] <= link_wd;
    link_rd_r <= link_mem[link_ra[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.word_we) word_mem[node_r[AW-1:0]] <= req_r.value;
    word_rd_r <= word_mem[word_ra[AW-1:0]];
  end

  // pointer and counter next values
  always_comb begin
    head_nxt  = head_r;
    free_nxt  = free_r;
    node_nxt  = node_r;
    cur_nxt   = cur_r;
    count_nxt = count_r;
    steps_nxt = steps_r;
    fwd_nxt   = fwd_r;
    case (cmd.head_upd)
      HEAD_NODE: head_nxt = node_r;
      HEAD_LRD:  head_nxt = link_rd_r;
      default:   head_nxt = head_r;
    endcase
    case (cmd.free_upd)
      FREE_LRD:  free_nxt = link_rd_r;
      FREE_NODE: free_nxt = node_r;
      default:   free_nxt = free_r;
    endcase
    case (cmd.node_sel)
      NODE_FREE: node_nxt = free_r;
      NODE_HEAD: node_nxt = head_r;
      NODE_LRD:  node_nxt = link_rd_r;
      default:   node_nxt = node_r;
    endcase
    if (cmd.cnt_inc) count_nxt = count_r + IW'(1);
    else if (cmd.cnt_dec) count_nxt = count_r - IW'(1);
    if (cmd.walk_start) begin
      cur_nxt   = head_r;
      fwd_nxt   = 1'b0;
      steps_nxt = req_r.position - (cmd.walk_skip ? 8'd2 : 8'd1);
    end else if (cmd.walk_step) begin
      steps_nxt = steps_r - 8'd1;
      fwd_nxt   = 1'b1;
      cur_nxt   = cur_x;
    end else if (cmd.walk_end) begin
      cur_nxt = cur_x;
      fwd_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NULL_IDX;
      free_r      <= '0;
      count_r     <= '0;
      fwd_r       <= 1'b0;
      init_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      free_r  <= free_nxt;
      count_r <= count_nxt;
      fwd_r   <= fwd_nxt;
      if (cmd.init_wr) init_idx_r <= init_idx_r + IW'(1);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    node_r  <= node_nxt;
    cur_r   <= cur_nxt;
    steps_r <= steps_nxt;
    if (cmd.req_load) begin
      req_r <= in_data;
      rd_r  <= '0;
    end else if (cmd.rd_load) begin
      rd_r <= word_rd_r;
    end
    if (cmd.status_load) status_r <= dec_status;
    if (cmd.out_load) begin
      out_data_r.read_value <= rd_r;
      out_data_r.status     <= status_r;
      out_data_r.item_count <= 8'(count_r);
      out_data_r.list_empty <= (count_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/slle_ctrl.sv -----
// request sequencer: clearing pass, position walk and list update steps
// depends on slle_pkg
`timescale 1ns / 1ps

module slle_ctrl import slle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  input  slle_sts_t sts,
  output slle_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.link_wr = LW_INIT;
        cmd.init_wr = 1'b1;
        if (sts.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.status_load = 1'b1;
        cmd.link_ra     = (sts.op == OP_INSERT) ? LRA_FREE : LRA_HEAD;
        cmd.word_ra     = WRA_HEAD;
        if (sts.err || sts.op == OP_NOP) begin
          state_nxt = S_FINISH;
        end else if (sts.op == OP_INSERT) begin
          cmd.node_sel = NODE_FREE;
          state_nxt    = S_INS_POP;
        end else if (sts.op == OP_REMOVE) begin
          cmd.node_sel = NODE_HEAD;
          if (sts.pos_one) begin
            state_nxt = S_REM_HEAD;
          end else begin
            cmd.walk_start = 1'b1;
            cmd.walk_skip  = 1'b1;
            state_nxt      = S_WALK;
          end
        end else begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_WALK;
        end
      end
      S_INS_POP: begin
        cmd.free_upd = FREE_LRD;
        cmd.word_we  = 1'b1;
        if (sts.pos_one) begin
          cmd.link_wr  = LW_NODE_HEAD;
          cmd.head_upd = HEAD_NODE;
          cmd.cnt_inc  = 1'b1;
          state_nxt    = S_FINISH;
        end else begin
          cmd.walk_start = 1'b1;
          cmd.walk_skip  = 1'b1;
          state_nxt      = S_WALK;
        end
      end
      S_WALK: begin
        cmd.link_ra = LRA_WALK;
        cmd.word_ra = WRA_WALK;
        if (!sts.steps_zero) begin
          cmd.walk_step = 1'b1;
        end else begin
          cmd.walk_end = 1'b1;
          case (sts.op)
            OP_INSERT: state_nxt = S_INS_WR_NODE;
            OP_REMOVE: state_nxt = S_REM_NODE;
            default:   state_nxt = S_RD_TAKE;
          endcase
        end
      end
      S_INS_WR_NODE: begin
        cmd.link_wr = LW_NODE_LRD;
        state_nxt   = S_INS_WR_PREV;
      end
      S_INS_WR_PREV: begin
        cmd.link_wr = LW_CUR_NODE;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_REM_HEAD: begin
        cmd.head_upd = HEAD_LRD;
        cmd.rd_load  = 1'b1;
        state_nxt    = S_REM_FREE;
      end
      S_REM_NODE: begin
        cmd.node_sel = NODE_LRD;
        cmd.link_ra  = LRA_LRD;
        cmd.word_ra  = WRA_LRD;
        state_nxt    = S_REM_UNLINK;
      end
      S_REM_UNLINK: begin
        cmd.link_wr = LW_CUR_LRD;
        cmd.rd_load = 1'b1;
        state_nxt   = S_REM_FREE;
      end
      S_REM_FREE: begin
        cmd.link_wr  = LW_NODE_FREE;
        cmd.free_upd = FREE_NODE;
        cmd.cnt_dec  = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_RD_TAKE: begin
        cmd.rd_load = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- tb/sv/slle_list_checker.sv -----
// transfer checker for the static linked list engine: tracks the list, predicts each answer
// depends on slle_pkg; instantiated beside the block by tb_static_linked_list_engine_core
`timescale 1ns / 1ps

module slle_list_checker import slle_pkg::*; #(
  parameter int DEPTH = 128
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  req_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  rsp_t out_data,
  output int   error_total,
  output int   answers_owed,
  output int   list_length
);

  localparam int unsigned NIL = DEPTH;

  // shadow of the node store, free list and element count
  int unsigned link_mem [DEPTH];
  logic [31:0] word_mem [DEPTH];
  int unsigned first_node;
  int unsigned free_node;
  int unsigned elem_cnt;

  rsp_t owed_answers [$];

  // entry at 1-based position pos, bounded walk from the head
  function automatic int unsigned node_at(int unsigned pos);
    int unsigned idx;
    int unsigned n;
    idx = first_node;
    for (n = 1; n < pos && n < DEPTH; n++) begin
      if (idx >= DEPTH) return NIL;
      idx = link_mem[idx];
    end
    return (idx < DEPTH) ? idx : NIL;
  endfunction

  // applies one request to the shadow list and returns its answer
  function automatic rsp_t apply_list_request(req_t r);
    rsp_t        ans;
    int unsigned pos;
    int unsigned node;
    int unsigned prev;
    ans        = '0;
    ans.status = STAT_OK;
    pos        = r.position;
    case (r.op)
      OP_INSERT: begin
        if (free_node >= DEPTH || elem_cnt >= DEPTH) begin
          ans.status = STAT_FULL;
        end else if (pos < 1 || pos > elem_cnt + 1) begin
          ans.status = STAT_RANGE;
        end else begin
          node           = free_node;
          free_node      = link_mem[node];
          word_mem[node] = r.value;
          if (pos == 1) begin
            link_mem[node] = first_node;
            first_node     = node;
          end else begin
            prev = node_at(pos - 1);
            if (prev < DEPTH) begin
              link_mem[node] = link_mem[prev];
              link_mem[prev] = node;
            end else begin
              link_mem[node] = free_node;
              free_node      = node;
              elem_cnt--;
            end
          end
          elem_cnt++;
        end
      end
      OP_REMOVE, OP_READ: begin
        if (pos < 1 || pos > elem_cnt) begin
          ans.status = STAT_RANGE;
        end else if (r.op == OP_READ) begin
          node = node_at(pos);
          if (node < DEPTH) ans.read_value = word_mem[node];
        end else begin
          node = NIL;
          if (pos == 1) begin
            node = first_node;
            if (node < DEPTH) first_node = link_mem[node];
          end else begin
            prev = node_at(pos - 1);
            if (prev < DEPTH) begin
              node = link_mem[prev];
              if (node < DEPTH) link_mem[prev] = link_mem[node];
            end
          end
          if (node < DEPTH) begin
            ans.read_value = word_mem[node];
            link_mem[node] = free_node;
            free_node      = node;
            elem_cnt--;
          end
        end
      end
      default: begin
      end
    endcase
    ans.item_count = elem_cnt[7:0];
    ans.list_empty = (elem_cnt == 0);
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst_n) begin
      first_node = NIL;
      free_node  = 0;
      elem_cnt   = 0;
      for (int i = 0; i < DEPTH; i++) begin
        link_mem[i] = i + 1;
        word_mem[i] = '0;
      end
      link_mem[DEPTH-1] = NIL;
      owed_answers.delete();
    end else begin
      // result first: a request taken at this edge cannot be answered at it
      if (out_valid && out_ready) begin
        if (owed_answers.size() == 0) begin
          error_total++;
          $display("%0t: unexpected result %h", $time, out_data);
        end else begin
          want = owed_answers.pop_front();
          if (out_data.read_value !== want.read_value) begin
            error_total++;
            $display("%0t: read_value expected %h got %h", $time, want.read_value,
                     out_data.read_value);
          end
          if (out_data.status !== want.status) begin
            error_total++;
            $display("%0t: status expected %0d got %0d", $time, want.status, out_data.status);
          end
          if (out_data.item_count !== want.item_count) begin
            error_total++;
            $display("%0t: item_count expected %0d got %0d", $time, want.item_count,
                     out_data.item_count);
          end
          if (out_data.list_empty !== want.list_empty) begin
            error_total++;
            $display("%0t: list_empty expected %b got %b", $time, want.list_empty,
                     out_data.list_empty);
          end
        end
      end
      if (in_valid && in_ready) owed_answers.push_back(apply_list_request(in_data));
    end
    answers_owed = owed_answers.size();
    list_length  = elem_cnt;
  end

endmodule

// ----- tb/sv/tb_static_linked_list_engine_core.sv -----
// top of the static linked list engine testbench: clock, reset, request and result traffic
// depends on slle_pkg, static_linked_list_engine_core and slle_list_checker
`timescale 1ns / 1ps

module tb_static_linked_list_engine_core import slle_pkg::*;;

  localparam int DEPTH = 128;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  int error_total;
  int answers_owed;
  int list_length;

  // traffic shaping, changed between phases
  int send_idle_pct;
  int recv_stall_pct;
  int hold_len;

  // random walk through list sizes: grow until full, then drain until empty
  bit growing;
  int full_hits;

  static_linked_list_engine_core #(.DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  slle_list_checker #(.DEPTH(DEPTH)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .error_total  (error_total),
    .answers_owed (answers_owed),
    .list_length  (list_length)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard limit, far above the slowest legal run, clearing pass included
  initial begin
    #30_000_000;
    $display("tb_static_linked_list_engine_core: errors");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0 && !hold_done) begin
        // keep ready low through the hold-off of hold_len so the block backs up into its input
        out_ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_req(logic [1:0] op, logic [7:0] pos, logic [31:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data.op       <= op;
    in_data.position <= pos;
    in_data.value    <= val;
    // valid holds with a stable payload until the transfer
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // random requests shaped by the current list length, mostly well formed
  task automatic run_random(int n);
    int          cnt;
    int          roll;
    logic [1:0]  op;
    logic [7:0]  pos;
    logic [31:0] val;
    int          top_pos;
    for (int k = 0; k < n; k++) begin
      // the checker updated its length at the last transfer edge
      cnt  = list_length;
      roll = $urandom_range(0, 99);
      val  = $urandom();
      if ($urandom_range(0, 15) == 0) val = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
      // switch direction at the ends of the size range
      if (growing && cnt == DEPTH) begin
        full_hits++;
        if (full_hits > 4) begin
          growing   = 1'b0;
          full_hits = 0;
        end
      end else if (!growing && cnt == 0) begin
        growing = 1'b1;
      end
      if (roll < 8) begin
        // noise: any op code, any position
        op  = 2'($urandom_range(0, 3));
        pos = 8'($urandom_range(0, 255));
      end else if (roll < 13) begin
        // position just outside or far outside the legal range
        op      = 2'($urandom_range(0, 2));
        top_pos = (op == OP_INSERT) ? cnt + 1 : cnt;
        pos     = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(top_pos + 1, 255));
      end else begin
        roll = $urandom_range(0, 99);
        if (growing) op = (roll < 65) ? OP_INSERT : (roll < 80) ? OP_REMOVE : OP_READ;
        else         op = (roll < 15) ? OP_INSERT : (roll < 80) ? OP_REMOVE : OP_READ;
        if (cnt == 0) op = OP_INSERT;
        top_pos = (op == OP_INSERT) ? cnt + 1 : cnt;
        // favor head and tail, otherwise anywhere in range
        roll = $urandom_range(0, 3);
        if (roll == 0)      pos = 8'd1;
        else if (roll == 1) pos = 8'(top_pos);
        else                pos = 8'($urandom_range(1, top_pos));
      end
      send_req(op, pos, val);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = 0;
    growing        = 1'b1;
    full_hits      = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // the clearing pass after reset holds in_ready low; the first transfer waits for it

    // directed: empty list errors, head/middle/tail inserts, reads, removes, unused op
    send_req(OP_READ,   8'd1,   32'h0);
    send_req(OP_REMOVE, 8'd1,   32'h0);
    send_req(OP_INSERT, 8'd0,   32'hdead_beef);
    send_req(OP_INSERT, 8'd2,   32'hdead_beef);
    send_req(OP_INSERT, 8'd1,   32'h0000_0000);
    send_req(OP_INSERT, 8'd2,   32'hffff_ffff);
    send_req(OP_INSERT, 8'd1,   32'h8000_0000);
    send_req(OP_INSERT, 8'd2,   32'h1234_5678);
    send_req(OP_INSERT, 8'd255, 32'h5555_aaaa);
    send_req(OP_NOP,    8'd255, 32'hffff_ffff);
    send_req(OP_READ,   8'd1,   32'h0);
    send_req(OP_READ,   8'd4,   32'h0);
    send_req(OP_READ,   8'd2,   32'h0);
    send_req(OP_READ,   8'd5,   32'h0);
    send_req(OP_READ,   8'd0,   32'h0);
    send_req(OP_READ,   8'd255, 32'h0);
    send_req(OP_REMOVE, 8'd0,   32'h0);
    send_req(OP_REMOVE, 8'd5,   32'h0);
    send_req(OP_REMOVE, 8'd4,   32'h0);
    send_req(OP_REMOVE, 8'd1,   32'h0);
    send_req(OP_REMOVE, 8'd2,   32'h0);
    send_req(OP_READ,   8'd1,   32'h0);
    send_req(OP_REMOVE, 8'd1,   32'h0);
    send_req(OP_NOP,    8'd0,   32'h0);

    // no idling at all
    run_random(250);

    // sender idle most cycles
    send_idle_pct = 73;
    run_random(200);

    // receiver stalls most cycles
    send_idle_pct  = 0;
    recv_stall_pct = 73;
    run_random(200);

    // both sides idle now and then
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    run_random(220);

    // long receiver hold-off while requests keep coming, so the input backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = 400;
    run_random(20);

    // drain: drop valid and let every owed result come back
    in_valid <= 1'b0;
    while (answers_owed != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);

    if (error_total == 0) begin
      $display("tb_static_linked_list_engine_core: clean");
    end else begin
      $display("tb_static_linked_list_engine_core: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/slle_pkg.sv
rtl/core/slle_datapath.sv
rtl/core/slle_ctrl.sv
rtl/core/static_linked_list_engine_core.sv
tb/sv/slle_list_checker.sv
tb/sv/tb_static_linked_list_engine_core.sv
